>>> sv/pigt_pkg.sv
package pigt_pkg;

   // Default palette depth and field widths.
   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int SIZE_W  = 9;
   localparam int GRAY_W  = 8;
   localparam int ENTRY_W = 9;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // Request kinds.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Conversion modes; the unused code behaves as plain conversion.
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_KEEP  = 2'd1;
   localparam logic [1:0] MODE_BG    = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_BG_GRAY = 2'd1;
   localparam logic [1:0] CSR_SIZE    = 2'd2;

   // Luma weights.
   localparam logic [6:0] LUMA_R   = 7'd77;
   localparam logic [7:0] LUMA_G   = 8'd150;
   localparam logic [4:0] LUMA_B   = 5'd29;
   localparam logic [15:0] LUMA_RND = 16'd128;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  entry_index;
      logic [31:0] entry_argb;
      logic [7:0]  pixel_index;
      logic [7:0]  dest_gray;
   } req_payload_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray_out;
      logic              written;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [GRAY_W-1:0] bg_gray;
      logic [SIZE_W-1:0] palette_size;
   } cfg_type;

endpackage

>>> sv/pigt_if.sv
interface pigt_req_if;
   import pigt_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pigt_rsp_if;
   import pigt_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/pigt_pipe.sv
module pigt_pipe #(
   parameter int PALETTE_DEPTH = pigt_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  pigt_pkg::cfg_type cfg,
   pigt_req_if.sink         req_chan,
   pigt_rsp_if.source       rsp_chan
);
   import pigt_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(PALETTE_DEPTH);

   // Stage 1: request fields and the three luma products.
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_type_ff;
   logic [7:0]        s1_slot_ff;
   logic              s1_opaque_ff;
   logic [14:0]       s1_pr_ff;
   logic [15:0]       s1_pg_ff;
   logic [12:0]       s1_pb_ff;
   logic [7:0]        s1_pix_ff;
   logic [7:0]        s1_dest_ff;

   // Stage 2: palette read data and pixel context.
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_inrange_ff;
   logic [7:0]        s2_dest_ff;
   logic [ENTRY_W-1:0] s2_entry_ff;

   // Stage 3: result register.
   logic              s3_valid_ff, s3_valid_in;
   rsp_payload_type   s3_rsp_ff, s3_rsp_in;

   logic [ENTRY_W-1:0] palette_mem [PALETTE_DEPTH];

   logic              req_accept;
   logic              s1_leave, s2_can, s2_load, s2_leave, s3_can;
   logic [SIZE_W-1:0] size_eff;
   logic              pix_ok, mem_we;
   logic [15:0]       luma_sum;
   logic              opaque;

   // Handshake flow: each stage moves when the next one has room; palette writes leave stage 1 without waiting.
   always_comb begin
      s3_can   = !s3_valid_ff || rsp_chan.ready;
      s2_leave = s2_valid_ff && s3_can;
      s2_can   = !s2_valid_ff || s2_leave;
      s2_load  = s1_valid_ff && (s1_type_ff == REQ_PIXEL) && s2_can;
      s1_leave = s1_valid_ff && ((s1_type_ff == REQ_WRITE) || s2_can);
      req_chan.ready = !s1_valid_ff || s1_leave;
      req_accept = req_chan.valid && req_chan.ready;
   end

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_leave ? 1'b0 : s1_valid_ff);
      s2_valid_in = s2_can ? (s1_valid_ff && (s1_type_ff == REQ_PIXEL)) : s2_valid_ff;
      s3_valid_in = s3_can ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1 capture, with the weighted colour channels.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff   <= req_chan.payload.req_type;
         s1_slot_ff   <= req_chan.payload.entry_index;
         s1_opaque_ff <= req_chan.payload.entry_argb[31];
         s1_pr_ff     <= 15'(req_chan.payload.entry_argb[23:16]) * 15'(LUMA_R);
         s1_pg_ff     <= 16'(req_chan.payload.entry_argb[15:8]) * 16'(LUMA_G);
         s1_pb_ff     <= 13'(req_chan.payload.entry_argb[7:0]) * 13'(LUMA_B);
         s1_pix_ff    <= req_chan.payload.pixel_index;
         s1_dest_ff   <= req_chan.payload.dest_gray;
      end
   end

   // Effective palette size and the rounded luma sum.
   always_comb begin
      size_eff = (cfg.palette_size > DEPTH_SZ) ? DEPTH_SZ : cfg.palette_size;
      pix_ok   = {1'b0, s1_pix_ff} < size_eff;
      mem_we   = s1_leave && (s1_type_ff == REQ_WRITE) && ({1'b0, s1_slot_ff} < DEPTH_SZ);
      luma_sum = 16'(s1_pr_ff) + s1_pg_ff + 16'(s1_pb_ff) + LUMA_RND;
   end

   // Palette store: writes and reads leave stage 1 in request order.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[s1_slot_ff[IDX_W-1:0]] <= {s1_opaque_ff, luma_sum[15:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_entry_ff   <= palette_mem[s1_pix_ff[IDX_W-1:0]];
         s2_inrange_ff <= pix_ok;
         s2_dest_ff    <= s1_dest_ff;
      end
   end

   // Result selection by mode.
   always_comb begin
      opaque = s2_inrange_ff && s2_entry_ff[ENTRY_W-1];
      case (cfg.mode)
         MODE_KEEP: begin
            s3_rsp_in.gray_out = opaque ? s2_entry_ff[GRAY_W-1:0] : s2_dest_ff;
            s3_rsp_in.written  = opaque;
         end
         MODE_BG: begin
            s3_rsp_in.gray_out = opaque ? s2_entry_ff[GRAY_W-1:0] : cfg.bg_gray;
            s3_rsp_in.written  = 1'b1;
         end
         default: begin
            s3_rsp_in.gray_out = s2_inrange_ff ? s2_entry_ff[GRAY_W-1:0] : '0;
            s3_rsp_in.written  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_leave) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   assign rsp_chan.valid   = s3_valid_ff;
   assign rsp_chan.payload = s3_rsp_ff;

endmodule

>>> sv/palette_index_to_gray_with_transparency.sv
// A pixel request's result passes the stage 1, stage 2 and stage 3 registers
// before it is presented on the result channel.
// Throughput: one request per cycle, pixels and palette writes alike, while results
// are taken; the three register stages are products, palette read and mode select.
// Reset is synchronous: it empties the pipeline and sets mode 0, background
// gray 0 and palette size 256. Palette contents stay undefined until written.
module palette_index_to_gray_with_transparency #(
   parameter int PALETTE_DEPTH = pigt_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   pigt_req_if.sink                     req_chan,
   pigt_rsp_if.source                   rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pigt_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [pigt_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [pigt_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import pigt_pkg::*;

   logic [1:0]        mode_ff;
   logic [GRAY_W-1:0] bg_gray_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              csr_write;
   logic [1:0]        csr_index;
   cfg_type           cfg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PLAIN;
         bg_gray_ff <= '0;
         size_ff    <= SIZE_W'(256);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff    <= csr_pwdata[1:0];
            CSR_BG_GRAY: bg_gray_ff <= csr_pwdata[GRAY_W-1:0];
            CSR_SIZE:    size_ff    <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back.
   always_comb begin
      unique case (csr_index)
         CSR_MODE:    csr_prdata = CSR_DW'(mode_ff);
         CSR_BG_GRAY: csr_prdata = CSR_DW'(bg_gray_ff);
         CSR_SIZE:    csr_prdata = CSR_DW'(size_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg.mode         = mode_ff;
   assign cfg.bg_gray      = bg_gray_ff;
   assign cfg.palette_size = size_ff;

   pigt_pipe #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_pipe (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

endmodule

>>> tb/sv/palette_index_to_gray_with_transparency_tb.sv
module palette_index_to_gray_with_transparency_tb;
   import pigt_pkg::*;

   // Pipeline depth of the block, used for the quiet time before register writes.
   localparam int LATENCY = 3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_REQUESTS = 85;

   typedef enum logic [1:0] {ROW_PALETTE, ROW_PIXEL, ROW_CSR} row_kind_type;

   // One directed step: a palette write, a pixel or a register write.
   // For a palette write slot is the entry and value the colour; for a pixel
   // slot is the index; for a register write slot is the register index.
   typedef struct {
      row_kind_type kind;
      logic [7:0]  slot;
      logic [31:0] value;
      logic [7:0]  dest;
      bit          typed;
      logic [7:0]  typed_gray;
      logic        typed_written;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   pigt_req_if req_chan ();
   pigt_rsp_if rsp_chan ();

   palette_index_to_gray_with_transparency dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the block: registers and the palette as luma plus opaque flag.
   logic [1:0]        shadow_mode;
   logic [GRAY_W-1:0] shadow_bg_gray;
   logic [SIZE_W-1:0] shadow_size;
   logic [ENTRY_W-1:0] luma_table [256];
   bit                 slot_loaded [256];
   int                 loaded_slots [$];

   // Gray results still owed by the block, oldest first.
   rsp_payload_type pending_grays [$];
   int mismatches = 0;

   // Idling controls, set per phase.
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;

   directed_row_type directed_rows [31] = '{
      '{ROW_PALETTE, 8'd0,   32'hFFFF_FFFF, 8'h00, 1'b0, 8'd0,   1'b0},
      '{ROW_PALETTE, 8'd255, 32'h0000_0000, 8'h00, 1'b0, 8'd0,   1'b0},
      '{ROW_PALETTE, 8'd1,   32'h80FF_0000, 8'h00, 1'b0, 8'd0,   1'b0},
      '{ROW_PALETTE, 8'd2,   32'h7F00_FF00, 8'h00, 1'b0, 8'd0,   1'b0},
      '{ROW_PALETTE, 8'd3,   32'h8000_00FF, 8'h00, 1'b0, 8'd0,   1'b0},
      '{ROW_PALETTE, 8'd4,   32'h0012_3456, 8'h00, 1'b0, 8'd0,   1'b0},
      '{ROW_PIXEL,   8'd0,   32'd0,         8'h00, 1'b1, 8'd255, 1'b1},
      '{ROW_PIXEL,   8'd255, 32'd0,         8'hFF, 1'b1, 8'd0,   1'b1},
      '{ROW_PIXEL,   8'd1,   32'd0,         8'hAA, 1'b1, 8'd77,  1'b1},
      '{ROW_PIXEL,   8'd2,   32'd0,         8'h55, 1'b1, 8'd149, 1'b1},
      '{ROW_PIXEL,   8'd3,   32'd0,         8'h00, 1'b1, 8'd29,  1'b1},
      '{ROW_PIXEL,   8'd4,   32'd0,         8'h80, 1'b0, 8'd0,   1'b0},
      '{ROW_CSR,     8'(CSR_SIZE),    32'd2,   8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_PIXEL,   8'd2,   32'd0,         8'h11, 1'b1, 8'd0,   1'b1},
      '{ROW_PIXEL,   8'd1,   32'd0,         8'h22, 1'b1, 8'd77,  1'b1},
      '{ROW_CSR,     8'(CSR_MODE),    32'(MODE_KEEP), 8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_PIXEL,   8'd255, 32'd0,         8'hA5, 1'b1, 8'hA5,  1'b0},
      '{ROW_CSR,     8'(CSR_SIZE),    32'd256, 8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_PIXEL,   8'd255, 32'd0,         8'h3C, 1'b1, 8'h3C,  1'b0},
      '{ROW_PIXEL,   8'd2,   32'd0,         8'hC3, 1'b1, 8'hC3,  1'b0},
      '{ROW_PIXEL,   8'd0,   32'd0,         8'h00, 1'b1, 8'd255, 1'b1},
      '{ROW_CSR,     8'(CSR_MODE),    32'(MODE_BG), 8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_CSR,     8'(CSR_BG_GRAY), 32'hFF,  8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_PIXEL,   8'd255, 32'd0,         8'h00, 1'b1, 8'hFF,  1'b1},
      '{ROW_PIXEL,   8'd1,   32'd0,         8'h00, 1'b1, 8'd77,  1'b1},
      '{ROW_CSR,     8'(CSR_SIZE),    32'd0,   8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_PIXEL,   8'd0,   32'd0,         8'h00, 1'b1, 8'hFF,  1'b1},
      '{ROW_CSR,     8'(CSR_MODE),    32'(MODE_UNUSED), 8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_CSR,     8'(CSR_SIZE),    32'd511, 8'h00, 1'b0, 8'd0, 1'b0},
      '{ROW_PIXEL,   8'd2,   32'd0,         8'h00, 1'b1, 8'd149, 1'b1},
      '{ROW_PIXEL,   8'd255, 32'd0,         8'h7E, 1'b1, 8'd0,   1'b1}
   };

   // Clock with a period of ten time units.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounded BT.601 luma of the colour channels.
   function automatic logic [7:0] luma_of_argb(input logic [31:0] argb);
      int sum;
      sum = 77 * argb[23:16] + 150 * argb[15:8] + 29 * argb[7:0] + 128;
      return 8'(sum >> 8);
   endfunction

   // Palette size as the block uses it, clamped to the store.
   function automatic int usable_entries();
      int n;
      n = int'(shadow_size);
      if (n > 256) n = 256;
      return n;
   endfunction

   // Gray and write flag that a pixel request should produce.
   function automatic rsp_payload_type predict_gray(input logic [7:0] idx,
                                                    input logic [7:0] dest);
      bit in_range;
      bit opaque;
      logic [ENTRY_W-1:0] entry;
      rsp_payload_type r;
      in_range = idx < usable_entries();
      entry = in_range ? luma_table[idx] : '0;
      opaque = in_range && entry[8];
      case (shadow_mode)
         MODE_KEEP: begin
            r.gray_out = opaque ? entry[7:0] : dest;
            r.written = opaque;
         end
         MODE_BG: begin
            r.gray_out = opaque ? entry[7:0] : shadow_bg_gray;
            r.written = 1'b1;
         end
         default: begin
            r.gray_out = in_range ? entry[7:0] : 8'd0;
            r.written = 1'b1;
         end
      endcase
      return r;
   endfunction

   // Offer one request, wait for it to be taken, then update the shadow state.
   task automatic push_request(input req_payload_type item, input bit typed,
                               input rsp_payload_type typed_rsp);
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (item.req_type == REQ_WRITE) begin
         luma_table[item.entry_index] = {item.entry_argb[31], luma_of_argb(item.entry_argb)};
         if (!slot_loaded[item.entry_index]) begin
            slot_loaded[item.entry_index] = 1'b1;
            loaded_slots.push_back(int'(item.entry_index));
         end
      end else if (typed) begin
         pending_grays.push_back(typed_rsp);
      end else begin
         pending_grays.push_back(predict_gray(item.pixel_index, item.dest_gray));
      end
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Stop sending and let the block drain fully before touching registers.
   task automatic drain_block();
      req_chan.valid <= 1'b0;
      while (pending_grays.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Register write with a setup phase and an access phase; the shadow copy follows it.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         CSR_MODE:    shadow_mode = value[1:0];
         CSR_BG_GRAY: shadow_bg_gray = value[7:0];
         CSR_SIZE:    shadow_size = value[8:0];
         default: ;
      endcase
   endtask

   // Result side: ready drops in random bursts while a phase allows it.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 13);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Each accepted result is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_grays.size() == 0) begin
            $error("unexpected result: gray_out %0d written %0d",
                   rsp_chan.payload.gray_out, rsp_chan.payload.written);
            mismatches++;
         end else begin
            want = pending_grays.pop_front();
            if (rsp_chan.payload.gray_out !== want.gray_out) begin
               $error("gray_out: expected %0d, actual %0d",
                      want.gray_out, rsp_chan.payload.gray_out);
               mismatches++;
            end
            if (rsp_chan.payload.written !== want.written) begin
               $error("written: expected %0d, actual %0d",
                      want.written, rsp_chan.payload.written);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, then randomised phases.
   initial begin
      req_payload_type item;
      rsp_payload_type typed_rsp;
      directed_row_type row;
      int eff;
      int write_pct;
      int size_pick;

      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      shadow_mode = MODE_PLAIN;
      shadow_bg_gray = '0;
      shadow_size = 9'd256;
      foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, every mode and the out-of-range cases.
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            drain_block();
            csr_write(row.slot[1:0], row.value);
         end else begin
            item.req_type = (row.kind == ROW_PALETTE) ? REQ_WRITE : REQ_PIXEL;
            item.entry_index = row.slot;
            item.entry_argb = row.value;
            item.pixel_index = row.slot;
            item.dest_gray = row.dest;
            typed_rsp.gray_out = row.typed_gray;
            typed_rsp.written = row.typed_written;
            push_request(item, row.typed, typed_rsp);
         end
      end

      // Random phases, each with its own register setting and idling level.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_block();
         csr_write(CSR_MODE, 32'($urandom_range(0, 3)));
         case ($urandom_range(0, 2))
            0: csr_write(CSR_BG_GRAY, 32'd0);
            1: csr_write(CSR_BG_GRAY, 32'd255);
            default: csr_write(CSR_BG_GRAY, 32'($urandom_range(0, 255)));
         endcase
         size_pick = $urandom_range(0, 9);
         case (size_pick)
            0: csr_write(CSR_SIZE, 32'd0);
            1: csr_write(CSR_SIZE, 32'd1);
            2: csr_write(CSR_SIZE, 32'd255);
            3: csr_write(CSR_SIZE, 32'd511);
            4, 5: csr_write(CSR_SIZE, 32'($urandom_range(2, 511)));
            default: csr_write(CSR_SIZE, 32'd256);
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct = 20 * $urandom_range(0, 2);
            rsp_stall_pct = 20 * $urandom_range(0, 2);
         end
         write_pct = (phase == 0) ? 60 : 25;
         eff = usable_entries();

         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            item.entry_index = 8'($urandom);
            item.entry_argb = $urandom;
            item.pixel_index = 8'($urandom);
            item.dest_gray = 8'($urandom);
            item.req_type = ($urandom_range(0, 99) < write_pct) ? REQ_WRITE : REQ_PIXEL;
            if (item.req_type == REQ_PIXEL) begin
               // Favour indices inside the palette, and only ones already loaded.
               if (eff > 0 && $urandom_range(0, 99) < 70)
                  item.pixel_index = 8'($urandom_range(0, eff - 1));
               if (item.pixel_index < eff && !slot_loaded[item.pixel_index])
                  item.pixel_index =
                     8'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
            end
            push_request(item, 1'b0, '0);
         end
      end

      // Let every outstanding result come back, then a short tail.
      req_chan.valid <= 1'b0;
      while (pending_grays.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
